// ===== hw/rtl/plr_pkg.sv =====
// Package for the piecewise-linear ramp lookup.
// It holds the request and response word types and the mode codes.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package plr_pkg;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam int POS_W = 16;
    localparam int VAL_W = 16;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] point_index;
        logic [POS_W-1:0] point_pos;
        logic [VAL_W-1:0] point_val_a;
        logic [VAL_W-1:0] point_val_b;
        logic [VAL_W-1:0] point_val_c;
        logic [POS_W-1:0] query_pos;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0] out_a;
        logic [VAL_W-1:0] out_b;
        logic [VAL_W-1:0] out_c;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module plr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/piecewise_linear_ramp_lookup.sv =====
// Top level of the piecewise-linear ramp lookup: control point store,
// scan sequencer and one shared multiply and restoring-divide unit.
// It depends on plr_pkg and plr_ram.
//
//   channel   direction   handshake                 word
//   req       in          req_valid / req_stall     plr_pkg::req_t
//   rsp       out         rsp_valid / rsp_stall     plr_pkg::rsp_t
//   cfg       in          cfg_write (no wait)       cfg_data, 7 bits
//
// A load word is written without making the block busy. A query compares with the first point,
// then with the last used point, and returns that point's values at or beyond either; an interior
// query then scans for j, the index of the first point not below the query; the scan reads
// one point a cycle from the single RAM port, then each of the three components
// passes through the shared unit (one multiply, 16 divide steps, one add).
// Reset is asynchronous, active low; the RAM contents are not cleared.
// A result waits in the output register while the next word is accepted.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_ramp_lookup #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire plr_pkg::req_t                   req,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output plr_pkg::rsp_t                        rsp,
    input  wire logic                            cfg_write,
    input  wire logic [plr_pkg::CNT_W-1:0]       cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int EW = plr_pkg::POS_W + 3 * plr_pkg::VAL_W;
    localparam int VW = 3 * plr_pkg::VAL_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_CHK0 = 4'd2;
    localparam logic [3:0] S_CHKL = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_PUT  = 4'd8;

    logic [3:0]                  state_reg, state_next;
    logic [plr_pkg::CNT_W-1:0]   count_reg;
    logic [plr_pkg::POS_W-1:0]   t_reg;
    logic [AW-1:0]               j_reg;
    logic [VW-1:0]               prev_reg;
    logic [VW-1:0]               cur_reg;
    logic [plr_pkg::POS_W-1:0]   prev_pos_reg;
    logic [plr_pkg::POS_W-1:0]   span_reg;
    logic [plr_pkg::POS_W-1:0]   dist_reg;
    logic [1:0]                  k_reg;
    logic                        neg_reg;
    logic [plr_pkg::VAL_W-1:0]   rem_reg;
    logic [plr_pkg::VAL_W-1:0]   qd_reg;
    logic [3:0]                  step_reg;
    logic [VW-1:0]               res_reg;
    logic                        rsp_valid_reg;
    plr_pkg::rsp_t               rsp_reg;

    logic                        req_take;
    logic                        idx_ok;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [EW-1:0]               wr_data;
    logic [AW-1:0]               rd_addr;
    logic [EW-1:0]               rd_data;
    logic [plr_pkg::POS_W-1:0]   rd_pos;
    logic [VW-1:0]               rd_val;
    logic [AW-1:0]               last_idx;
    logic [plr_pkg::VAL_W-1:0]   hi_val, lo_val;
    logic [plr_pkg::VAL_W-1:0]   mag;
    logic [2*plr_pkg::VAL_W-1:0] prod;
    logic [plr_pkg::VAL_W:0]     trial;
    logic                        trial_ge;
    logic [plr_pkg::VAL_W:0]     trial_sub;
    logic [plr_pkg::VAL_W-1:0]   comp_res;
    logic                        put_ok;

    assign req_take = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign put_ok = !rsp_valid_reg || !rsp_stall;

    assign idx_ok  = (32'(req.point_index) < MAX_POINTS);
    assign wr_en   = req_take && (req.mode == plr_pkg::MODE_LOAD) && idx_ok;
    assign wr_addr = AW'(req.point_index);
    assign wr_data = {req.point_val_c, req.point_val_b, req.point_val_a, req.point_pos};

    assign rd_pos = rd_data[plr_pkg::POS_W-1:0];
    assign rd_val = rd_data[EW-1:plr_pkg::POS_W];

    // A point count of zero acts as one; a count above the store saturates.
    always_comb
    begin
        if (count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(count_reg) > MAX_POINTS)
        begin
            last_idx = AW'(MAX_POINTS - 1);
        end
        else
        begin
            last_idx = AW'(count_reg - 7'd1);
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_CHK0:  rd_addr = last_idx;
            S_CHKL:  rd_addr = AW'(1);
            S_SCAN:  rd_addr = j_reg + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    plr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Component select for the shared unit: hi is point j, lo is point j-1.
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                hi_val = cur_reg[15:0];
                lo_val = prev_reg[15:0];
            end
            2'd1:
            begin
                hi_val = cur_reg[31:16];
                lo_val = prev_reg[31:16];
            end
            default:
            begin
                hi_val = cur_reg[47:32];
                lo_val = prev_reg[47:32];
            end
        endcase
    end

    assign mag  = (lo_val < hi_val) ? (hi_val - lo_val) : (lo_val - hi_val);
    assign prod = mag * dist_reg;

    // The product stays below mag * span, so its upper half is already below
    // the span and sixteen restoring steps give the whole quotient.
    assign trial     = {rem_reg, qd_reg[plr_pkg::VAL_W-1]};
    assign trial_ge  = (trial >= {1'b0, span_reg});
    assign trial_sub = trial - {1'b0, span_reg};

    // The quotient never exceeds the value gap, so the sum stays in range.
    assign comp_res = neg_reg ? (hi_val - qd_reg) : (hi_val + qd_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take && (req.mode == plr_pkg::MODE_QUERY))
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                state_next = S_CHK0;
            end
            S_CHK0:
            begin
                state_next = (t_reg <= rd_pos) ? S_PUT : S_CHKL;
            end
            S_CHKL:
            begin
                state_next = (t_reg >= rd_pos) ? S_PUT : S_SCAN;
            end
            S_SCAN:
            begin
                if (!(t_reg > rd_pos))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == 4'd15)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = (k_reg == 2'd2) ? S_PUT : S_MUL;
            end
            S_PUT:
            begin
                if (put_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= 7'd1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                count_reg <= cfg_data;
            end
            if (state_reg == S_PUT && put_ok)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                t_reg <= req.query_pos;
            end
            S_CHK0:
            begin
                prev_reg     <= rd_val;
                prev_pos_reg <= rd_pos;
                res_reg      <= rd_val;
                j_reg        <= AW'(1);
            end
            S_CHKL:
            begin
                res_reg <= rd_val;
            end
            S_SCAN:
            begin
                if (t_reg > rd_pos)
                begin
                    prev_reg     <= rd_val;
                    prev_pos_reg <= rd_pos;
                    j_reg        <= j_reg + AW'(1);
                end
                else
                begin
                    cur_reg  <= rd_val;
                    span_reg <= rd_pos - prev_pos_reg;
                    dist_reg <= rd_pos - t_reg;
                    k_reg    <= 2'd0;
                end
            end
            S_MUL:
            begin
                neg_reg  <= (lo_val < hi_val);
                rem_reg  <= prod[2*plr_pkg::VAL_W-1:plr_pkg::VAL_W];
                qd_reg   <= prod[plr_pkg::VAL_W-1:0];
                step_reg <= 4'd0;
            end
            S_DIV:
            begin
                rem_reg  <= trial_ge ? trial_sub[plr_pkg::VAL_W-1:0]
                                     : trial[plr_pkg::VAL_W-1:0];
                qd_reg   <= {qd_reg[plr_pkg::VAL_W-2:0], trial_ge};
                step_reg <= step_reg + 4'd1;
            end
            S_FIN:
            begin
                res_reg[16*k_reg +: 16] <= comp_res;
                k_reg <= k_reg + 2'd1;
            end
            S_PUT:
            begin
                if (put_ok)
                begin
                    rsp_reg.out_a <= res_reg[15:0];
                    rsp_reg.out_b <= res_reg[31:16];
                    rsp_reg.out_c <= res_reg[47:32];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/plr_checker.sv =====
// Port-level checker for the piecewise-linear ramp lookup, with its bind.
// It depends on plr_pkg and on the ports of piecewise_linear_ramp_lookup.
`timescale 1ns / 1ps
`default_nettype none

module plr_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      req_valid,
    input wire logic                      req_stall,
    input wire plr_pkg::req_t             req,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_stall,
    input wire plr_pkg::rsp_t             rsp
);

    // A waiting result word keeps its value until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result word changed or dropped while stalled");

    // A query keeps the block busy in the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.mode == plr_pkg::MODE_QUERY |=> req_stall)
        else $error("query accepted but block not busy");

    // A load word does not make the block busy.
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.mode == plr_pkg::MODE_LOAD |=> !req_stall)
        else $error("load word kept the block busy");

    // A new result only comes out of a query that was in work.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result word appeared without a query in work");

endmodule

bind piecewise_linear_ramp_lookup plr_checker u_plr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// ===== tb/sv/piecewise_linear_ramp_lookup_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise-linear ramp lookup: loads control points,
// queries the ramp and compares every result with its own interpolation of the points.
// It depends on plr_pkg and the piecewise_linear_ramp_lookup top level.

class ramp_checker;
    logic [plr_pkg::POS_W-1:0] pos_mem [64];
    plr_pkg::rsp_t             val_mem [64];
    logic [plr_pkg::CNT_W-1:0] count_reg;
    plr_pkg::rsp_t             expected_rsp [$];
    int                        errors;
    int                        checked;

    function new();
        count_reg = 1;
        errors    = 0;
        checked   = 0;
    endfunction

    function void set_count(logic [plr_pkg::CNT_W-1:0] v);
        count_reg = v;
    endfunction

    function int used_points();
        int n;
        n = int'(count_reg);
        if (n < 1) n = 1;
        if (n > 64) n = 64;
        return n;
    endfunction

    function int pending();
        return expected_rsp.size();
    endfunction

    // One component: the upper value pulled toward the lower one, truncated toward zero.
    function logic [plr_pkg::VAL_W-1:0] blend(logic [plr_pkg::VAL_W-1:0] hi,
                                              logic [plr_pkg::VAL_W-1:0] lo,
                                              longint to_hi, longint span);
        longint v;
        v = longint'(hi) + ((longint'(lo) - longint'(hi)) * to_hi) / span;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[plr_pkg::VAL_W-1:0];
    endfunction

    function plr_pkg::rsp_t eval_ramp(logic [plr_pkg::POS_W-1:0] t);
        int            n;
        int            j;
        longint        span;
        longint        to_hi;
        plr_pkg::rsp_t r;
        n = used_points();
        if (t <= pos_mem[0]) return val_mem[0];
        if (t >= pos_mem[n-1]) return val_mem[n-1];
        j = 0;
        while (j < n && t > pos_mem[j]) j++;
        span  = longint'(pos_mem[j]) - longint'(pos_mem[j-1]);
        to_hi = longint'(pos_mem[j]) - longint'(t);
        r.out_a = blend(val_mem[j].out_a, val_mem[j-1].out_a, to_hi, span);
        r.out_b = blend(val_mem[j].out_b, val_mem[j-1].out_b, to_hi, span);
        r.out_c = blend(val_mem[j].out_c, val_mem[j-1].out_c, to_hi, span);
        return r;
    endfunction

    function void note_word(plr_pkg::req_t w);
        if (w.mode == plr_pkg::MODE_LOAD)
        begin
            pos_mem[w.point_index]       = w.point_pos;
            val_mem[w.point_index].out_a = w.point_val_a;
            val_mem[w.point_index].out_b = w.point_val_b;
            val_mem[w.point_index].out_c = w.point_val_c;
        end
        else
        begin
            expected_rsp.push_back(eval_ramp(w.query_pos));
        end
    endfunction

    function void check_field(string name, logic [plr_pkg::VAL_W-1:0] want,
                              logic [plr_pkg::VAL_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    function void check_result(plr_pkg::rsp_t got);
        plr_pkg::rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            errors++;
            $display("%0t: result word with nothing expected, expected none, got %h",
                     $time, got);
            return;
        end
        want = expected_rsp.pop_front();
        checked++;
        check_field("out_a", want.out_a, got.out_a);
        check_field("out_b", want.out_b, got.out_b);
        check_field("out_c", want.out_c, got.out_c);
    endfunction
endclass

module piecewise_linear_ramp_lookup_tb;

    localparam int MAX_PTS     = 64;
    localparam int ITEM_GOAL   = 1600;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 16;
    localparam int TAIL        = 200;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_stall;
    plr_pkg::req_t             req;
    logic                      rsp_valid;
    logic                      rsp_stall;
    plr_pkg::rsp_t             rsp;
    logic                      cfg_write;
    logic [plr_pkg::CNT_W-1:0] cfg_data;

    ramp_checker tracker;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          items_sent;
    int          loads_sent;
    int          queries_sent;
    int          count_writes;
    int          cycle_count;

    piecewise_linear_ramp_lookup #(
        .MAX_POINTS(MAX_PTS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cfg_write(cfg_write),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[piecewise_linear_ramp_lookup] ERROR");
            $finish;
        end
    end

    // Result side: check each accepted word and stall at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                tracker.check_result(rsp);
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [plr_pkg::VAL_W-1:0] pick_val();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return plr_pkg::VAL_W'($urandom);
        endcase
    endfunction

    function automatic plr_pkg::req_t random_word();
        plr_pkg::req_t w;
        logic [95:0]   noise;
        noise = {$urandom, $urandom, $urandom};
        w = noise[$bits(plr_pkg::req_t)-1:0];
        return w;
    endfunction

    function automatic plr_pkg::req_t make_load(logic [plr_pkg::IDX_W-1:0] idx,
                                                logic [plr_pkg::POS_W-1:0] pos,
                                                logic [plr_pkg::VAL_W-1:0] a,
                                                logic [plr_pkg::VAL_W-1:0] b,
                                                logic [plr_pkg::VAL_W-1:0] c);
        plr_pkg::req_t w;
        w = random_word();
        w.mode        = plr_pkg::MODE_LOAD;
        w.point_index = idx;
        w.point_pos   = pos;
        w.point_val_a = a;
        w.point_val_b = b;
        w.point_val_c = c;
        return w;
    endfunction

    function automatic plr_pkg::req_t make_query(logic [plr_pkg::POS_W-1:0] t);
        plr_pkg::req_t w;
        w = random_word();
        w.mode      = plr_pkg::MODE_QUERY;
        w.query_pos = t;
        return w;
    endfunction

    task automatic send_word(input plr_pkg::req_t w);
        if (items_sent < ITEM_GOAL / 3)
        begin
            send_idle_pct = 22;
            recv_idle_pct = 68;
        end
        else if (items_sent < 2 * ITEM_GOAL / 3)
        begin
            send_idle_pct = 68;
            recv_idle_pct = 22;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        tracker.note_word(w);
        items_sent++;
        if (w.mode == plr_pkg::MODE_LOAD) loads_sent++;
        else queries_sent++;
    endtask

    // Holds the sender until every query has answered and the block has gone quiet.
    task automatic settle_block();
        req_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(input logic [plr_pkg::CNT_W-1:0] v);
        settle_block();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.set_count(v);
        count_writes++;
    endtask

    // Writes points 0..n-1: mostly ascending with the odd repeat, sometimes in any order.
    task automatic load_ramp(input int n);
        int                        stride;
        int                        k;
        bit                        scrambled;
        logic [plr_pkg::POS_W-1:0] p;
        logic [plr_pkg::POS_W-1:0] prev;
        stride    = 65536 / n;
        scrambled = ($urandom_range(9) == 0);
        prev      = '0;
        for (k = 0; k < n; k++)
        begin
            if (scrambled)
                p = plr_pkg::POS_W'($urandom);
            else if (k > 0 && $urandom_range(9) == 0)
                p = prev;
            else
                p = plr_pkg::POS_W'(k * stride + $urandom_range(0, stride - 1));
            send_word(make_load(plr_pkg::IDX_W'(k), p, pick_val(), pick_val(), pick_val()));
            prev = p;
        end
    endtask

    function automatic logic [plr_pkg::POS_W-1:0] pick_query(int n);
        int                        k;
        int                        lo;
        int                        hi;
        logic [plr_pkg::POS_W-1:0] p;
        k = $urandom_range(0, n - 1);
        p = tracker.pos_mem[k];
        case ($urandom_range(5))
            0: return plr_pkg::POS_W'($urandom);
            1: return p;
            2: return p + 1'b1;
            3: return p - 1'b1;
            4: return $urandom_range(1) ? '1 : '0;
            default:
            begin
                if (k == n - 1) return p;
                lo = int'(tracker.pos_mem[k]);
                hi = int'(tracker.pos_mem[k+1]);
                if (lo > hi) return plr_pkg::POS_W'($urandom_range(hi, lo));
                return plr_pkg::POS_W'($urandom_range(lo, hi));
            end
        endcase
    endfunction

    initial
    begin
        int                        n;
        int                        sel;
        logic [plr_pkg::CNT_W-1:0] reg_val;
        tracker       = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent    = 0;
        loads_sent    = 0;
        queries_sent  = 0;
        count_writes  = 0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_stall     = 1'b0;
        cfg_write     = 1'b0;
        cfg_data      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single point after reset: every query returns that point.
        send_word(make_load(6'd0, 16'h4000, 16'hFFFF, 16'h0000, 16'h8000));
        send_word(make_query(16'h0000));
        send_word(make_query(16'h4000));
        send_word(make_query(16'hFFFF));

        // A point count of zero behaves as one.
        write_count(7'd0);
        send_word(make_query(16'h3FFF));
        send_word(make_query(16'h4001));

        // Four points spanning the whole range, with extreme values.
        write_count(7'd4);
        send_word(make_load(6'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'h1234));
        send_word(make_load(6'd1, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000));
        send_word(make_load(6'd2, 16'h8000, 16'h0001, 16'hFFFE, 16'h7FFF));
        send_word(make_load(6'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_word(make_query(16'h0000));
        send_word(make_query(16'h0001));
        send_word(make_query(16'h0002));
        send_word(make_query(16'h7FFF));
        send_word(make_query(16'h8000));
        send_word(make_query(16'h8001));
        send_word(make_query(16'hFFFE));
        send_word(make_query(16'hFFFF));

        while (items_sent < ITEM_GOAL)
        begin
            sel = $urandom_range(99);
            if (sel < 8) n = 64;
            else if (sel < 16) n = 1;
            else if (sel < 30) n = $urandom_range(9, 63);
            else n = $urandom_range(2, 8);
            reg_val = plr_pkg::CNT_W'(n);
            if (n == 64 && $urandom_range(1))
                reg_val = plr_pkg::CNT_W'($urandom_range(65, 127));
            if (n == 1 && $urandom_range(1)) reg_val = '0;
            write_count(reg_val);
            load_ramp(n);
            repeat ($urandom_range(12, 30))
            begin
                if ($urandom_range(99) < 10)
                    send_word(make_load(plr_pkg::IDX_W'($urandom),
                                        plr_pkg::POS_W'($urandom),
                                        pick_val(), pick_val(), pick_val()));
                else
                    send_word(make_query(pick_query(n)));
            end
        end

        settle_block();
        repeat (TAIL) @(posedge clk);
        $display("Sent %0d load words and %0d queries under %0d point-count settings.",
                 loads_sent, queries_sent, count_writes);
        $display("Checked %0d result words, %0d errors.", tracker.checked, tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("[piecewise_linear_ramp_lookup] OK");
        else
            $display("[piecewise_linear_ramp_lookup] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/plr_pkg.sv
hw/rtl/plr_ram.sv
hw/rtl/piecewise_linear_ramp_lookup.sv
hw/rtl/plr_checker.sv
tb/sv/piecewise_linear_ramp_lookup_tb.sv
